// ===== hw/rtl/fqs_pkg.sv =====
// fqs_pkg: shared widths, request modes and result status codes
// for the searchable fifo queue; no dependencies
package fqs_pkg;

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  localparam int DEPTH_DEFAULT = 16;

  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SRCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage

// ===== hw/rtl/fqs_req_if.sv =====
// fqs_req_if: request channel (valid/ready) carrying mode and value
// depends on fqs_pkg for field widths
interface fqs_req_if;
  logic                             valid;
  logic                             ready;
  logic [fqs_pkg::MODE_W-1:0]       mode;
  logic signed [fqs_pkg::DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== hw/rtl/fqs_rsp_if.sv =====
// fqs_rsp_if: result channel (valid/ready) carrying status, data_out, position
// depends on fqs_pkg for field widths
interface fqs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fqs_pkg::STATUS_W-1:0]      status;
  logic signed [fqs_pkg::DATA_W-1:0] data_out;
  logic [fqs_pkg::POS_W-1:0]         position;

  modport source (output valid, output status, output data_out, output position, input ready);
  modport sink   (input valid, input status, input data_out, input position, output ready);
endinterface

// ===== hw/rtl/fqs_ram.sv =====
// fqs_ram: ring entry store, one write port and one read port, registered read
// depends on fqs_pkg for the word width
module fqs_ram #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  logic [fqs_pkg::DATA_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]            raddr,
  output logic [fqs_pkg::DATA_W-1:0]          rdata
);
  import fqs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fifo_queue_with_search.sv =====
// fifo_queue_with_search: bounded fifo of 32-bit signed words with a linear search
// depends on fqs_pkg, fqs_req_if, fqs_rsp_if and fqs_ram
//
// req channel: one word per request, mode selects enqueue, dequeue or search
// of value; mode 3 is a no-op answered with all-zero fields.
// rsp channel: exactly one result word per request, in request order.
// entries live in a single-port-read ring memory of DEPTH words; head, tail and
// count sit in flops.
// every accepted request ends in S_RESP, where its result loads into the output
// register; a dequeue passes S_DEQ first for the registered memory read, and a
// search stays in S_SRCH comparing up to the fill count of entries, the one
// memory read port walking the ring from the head one entry a cycle.
// one request is in flight at a time; the next is taken the cycle after the
// previous result moves to the output register, so a result waiting on a
// stalled receiver does not block the next request from being worked.
// when rsp.ready is low the result word holds and the block stalls once it has
// a second result ready.
// reset (rst, synchronous) empties the queue and drops any pending result;
// memory contents are not cleared and are never read before being written.
module fifo_queue_with_search #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  fqs_req_if.sink    req,
  fqs_rsp_if.source  rsp
);
  import fqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_SRCH = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [AW-1:0]       head, head_next;
  logic [AW-1:0]       tail, tail_next;
  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       scan_ptr, scan_ptr_next;
  logic [CW-1:0]       cmp_k, cmp_k_next;
  logic [CW-1:0]       cmp_k_inc;
  logic [DATA_W-1:0]   key, key_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [DATA_W-1:0]   res_data, res_data_next;
  logic [POS_W-1:0]    res_pos, res_pos_next;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic                out_load;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  fqs_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign cmp_k_inc = cmp_k + CW'(1);
  assign out_load  = (state == S_RESP) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    scan_ptr_next   = scan_ptr;
    cmp_k_next      = cmp_k;
    key_next        = key;
    res_status_next = res_status;
    res_data_next   = res_data;
    res_pos_next    = res_pos;
    ram_we          = 1'b0;
    ram_waddr       = tail;
    ram_wdata       = req.value;
    ram_raddr       = scan_ptr;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          key_next        = req.value;
          res_status_next = ST_OK;
          res_data_next   = '0;
          res_pos_next    = '0;
          state_next      = S_RESP;
          unique case (req.mode)
            MODE_ENQ: begin
              if (count == CW'(DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                tail_next  = ring_inc(tail);
                count_next = count + CW'(1);
              end
            end
            MODE_DEQ: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                ram_raddr  = head;
                head_next  = ring_inc(head);
                count_next = count - CW'(1);
                state_next = S_DEQ;
              end
            end
            MODE_SRCH: begin
              if (count == '0) begin
                res_status_next = ST_NOTFOUND;
              end else begin
                ram_raddr     = head;
                scan_ptr_next = ring_inc(head);
                cmp_k_next    = '0;
                state_next    = S_SRCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        res_data_next = ram_rdata;
        state_next    = S_RESP;
      end
      S_SRCH: begin
        if (ram_rdata == key) begin
          res_pos_next = POS_W'(cmp_k_inc);
          state_next   = S_RESP;
        end else if (cmp_k_inc == count) begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_RESP;
        end else begin
          scan_ptr_next = ring_inc(scan_ptr);
          cmp_k_next    = cmp_k_inc;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr   <= scan_ptr_next;
    cmp_k      <= cmp_k_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_pos    <= res_pos_next;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status   <= res_status;
      rsp.data_out <= res_data;
      rsp.position <= res_pos;
    end
  end

`ifndef SYNTH
  logic [CW-1:0] ring_dist;
  assign ring_dist = (tail >= head) ? CW'(tail - head)
                                    : CW'(tail) + CW'(DEPTH) - CW'(head);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    (ring_dist == count) || ((count == CW'(DEPTH)) && (ring_dist == '0)))
    else $error("head, tail and count disagree");

  a_search_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |=> ($stable(count) && $stable(head) && $stable(tail)))
    else $error("queue changed during search");

  a_pos_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.position != '0)) |-> ((rsp.status == ST_OK) && (rsp.data_out == '0)))
    else $error("position reported without a clean hit");

  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == S_RESP))
    else $error("result word raised outside response state");
`endif

endmodule
